// File: src/mtk_pkg.sv
// ----------------------------------------------------------------------------
// mtk_pkg: shared types and constants for the Morse time keyer
// Register indexes, reset values, queue entry and config types, digit table.
// ----------------------------------------------------------------------------
`default_nettype none

package mtk_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned DurW     = 11;

  localparam logic [CfgIdxW-1:0] CfgUse24Hour  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDotMs      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDashMs     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgElemGapMs  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDigitGapMs = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWordGapMs  = 3'd5;

  localparam logic [CfgDataW-1:0] RstDotMs      = 10'd100;
  localparam logic [CfgDataW-1:0] RstDashMs     = 10'd300;
  localparam logic [CfgDataW-1:0] RstElemGapMs  = 10'd100;
  localparam logic [CfgDataW-1:0] RstDigitGapMs = 10'd300;
  localparam logic [CfgDataW-1:0] RstWordGapMs  = 10'd700;

  localparam logic [1:0] SlotHourTens = 2'd0;
  localparam logic [1:0] SlotHourUnit = 2'd1;
  localparam logic [1:0] SlotMinTens  = 2'd2;
  localparam logic [1:0] SlotMinUnit  = 2'd3;
  localparam logic [2:0] LastElem     = 3'd4;

  typedef struct packed {
    logic                use_24_hour;
    logic [CfgDataW-1:0] dot_ms;
    logic [CfgDataW-1:0] dash_ms;
    logic [CfgDataW-1:0] element_gap_ms;
    logic [CfgDataW-1:0] digit_gap_ms;
    logic [CfgDataW-1:0] word_gap_ms;
  } cfg_t;

  // one classified request: dash masks for the four digit slots
  typedef struct packed {
    logic [3:0][4:0] masks;
    logic            skip_hour;
  } cmd_t;

  typedef struct packed {
    logic [DurW-1:0] duration_ms;
    logic            motor_on;
    logic [1:0]      digit_slot;
    logic            last_segment;
  } seg_t;

  typedef enum logic [1:0] {
    PhIdle,
    PhOn,
    PhGap
  } seg_phase_e;

  // bit i set: element i of the digit is a dash
  function automatic logic [4:0] morse_mask(input logic [3:0] digit);
    logic [4:0] m;
    case (digit)
      4'd0:    m = 5'h1F;
      4'd1:    m = 5'h1E;
      4'd2:    m = 5'h1C;
      4'd3:    m = 5'h18;
      4'd4:    m = 5'h10;
      4'd5:    m = 5'h00;
      4'd6:    m = 5'h01;
      4'd7:    m = 5'h03;
      4'd8:    m = 5'h07;
      4'd9:    m = 5'h0F;
      default: m = 5'h1F;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/mtk_front.sv
// ----------------------------------------------------------------------------
// mtk_front: request classifier
// Folds the hour, splits hour and minute into decimal digits and looks up
// the dash mask of each digit.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_front (
  input  wire logic       use_24_hour_i,
  input  wire logic [4:0] hour_i,
  input  wire logic [5:0] minute_i,
  input  wire logic       skip_hour_i,
  output mtk_pkg::cmd_t   cmd_o
);

  logic [4:0] hour_fold;
  logic [4:0] hour_12;
  logic [4:0] hour_sel;
  logic [3:0] hour_tens;
  logic [4:0] hour_unit;
  logic [3:0] min_tens;
  logic [5:0] min_unit;

  // 12-hour fold: mod 12 by compare and subtract, 0 reads as 12
  always_comb begin
    if (hour_i >= 5'd24) begin
      hour_fold = hour_i - 5'd24;
    end else if (hour_i >= 5'd12) begin
      hour_fold = hour_i - 5'd12;
    end else begin
      hour_fold = hour_i;
    end
    hour_12  = (hour_fold == 5'd0) ? 5'd12 : hour_fold;
    hour_sel = use_24_hour_i ? hour_i : hour_12;
  end

  always_comb begin
    if (hour_sel >= 5'd30) begin
      hour_tens = 4'd3;
      hour_unit = hour_sel - 5'd30;
    end else if (hour_sel >= 5'd20) begin
      hour_tens = 4'd2;
      hour_unit = hour_sel - 5'd20;
    end else if (hour_sel >= 5'd10) begin
      hour_tens = 4'd1;
      hour_unit = hour_sel - 5'd10;
    end else begin
      hour_tens = 4'd0;
      hour_unit = hour_sel;
    end
  end

  always_comb begin
    if (minute_i >= 6'd60) begin
      min_tens = 4'd6;
      min_unit = minute_i - 6'd60;
    end else if (minute_i >= 6'd50) begin
      min_tens = 4'd5;
      min_unit = minute_i - 6'd50;
    end else if (minute_i >= 6'd40) begin
      min_tens = 4'd4;
      min_unit = minute_i - 6'd40;
    end else if (minute_i >= 6'd30) begin
      min_tens = 4'd3;
      min_unit = minute_i - 6'd30;
    end else if (minute_i >= 6'd20) begin
      min_tens = 4'd2;
      min_unit = minute_i - 6'd20;
    end else if (minute_i >= 6'd10) begin
      min_tens = 4'd1;
      min_unit = minute_i - 6'd10;
    end else begin
      min_tens = 4'd0;
      min_unit = minute_i;
    end
  end

  always_comb begin
    cmd_o.masks[mtk_pkg::SlotHourTens] = mtk_pkg::morse_mask(hour_tens);
    cmd_o.masks[mtk_pkg::SlotHourUnit] = mtk_pkg::morse_mask(hour_unit[3:0]);
    cmd_o.masks[mtk_pkg::SlotMinTens]  = mtk_pkg::morse_mask(min_tens);
    cmd_o.masks[mtk_pkg::SlotMinUnit]  = mtk_pkg::morse_mask(min_unit[3:0]);
    cmd_o.skip_hour                    = skip_hour_i;
  end

endmodule

`default_nettype wire

// File: src/mtk_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mtk_cmd_fifo: short request queue
// Holds classified requests between the classifier and the segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire mtk_pkg::cmd_t wr_data_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output mtk_pkg::cmd_t      rd_data_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mtk_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/mtk_back.sv
// ----------------------------------------------------------------------------
// mtk_back: segment sequencer
// Walks digits and elements of one request into an output register, one
// segment per cycle unless a held-off pop stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mtk_pkg::cfg_t cfg_i,
  input  wire mtk_pkg::cmd_t cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_take_o,
  input  wire logic          pop_i,
  output logic               out_valid_o,
  output mtk_pkg::seg_t      out_seg_o
);

  mtk_pkg::seg_phase_e state_q, state_d;
  mtk_pkg::cmd_t       cmd_q, cmd_d;
  logic [1:0]          dig_q, dig_d;
  logic [2:0]          elem_q, elem_d;
  logic                out_valid_q, out_valid_d;
  mtk_pkg::seg_t       out_seg_q;
  mtk_pkg::seg_t       seg;
  logic                advance;
  logic                is_last;
  logic                elem_dash;
  logic [mtk_pkg::DurW-1:0] word_add;

  // output register frees when empty or being popped
  assign advance   = (state_q != mtk_pkg::PhIdle) && (!out_valid_q || pop_i);
  assign is_last   = (dig_q == mtk_pkg::SlotMinUnit) && (elem_q == mtk_pkg::LastElem);
  assign elem_dash = cmd_q.masks[dig_q][elem_q];

  // next state
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    dig_d   = dig_q;
    elem_d  = elem_q;
    case (state_q)
      mtk_pkg::PhIdle: begin
        if (!cmd_empty_i) begin
          state_d = mtk_pkg::PhOn;
          cmd_d   = cmd_i;
          dig_d   = cmd_i.skip_hour ? mtk_pkg::SlotMinTens : mtk_pkg::SlotHourTens;
          elem_d  = '0;
        end
      end
      mtk_pkg::PhOn: begin
        if (advance) begin
          if (is_last) begin
            if (!cmd_empty_i) begin
              cmd_d   = cmd_i;
              dig_d   = cmd_i.skip_hour ? mtk_pkg::SlotMinTens : mtk_pkg::SlotHourTens;
              elem_d  = '0;
            end else begin
              state_d = mtk_pkg::PhIdle;
            end
          end else begin
            state_d = mtk_pkg::PhGap;
          end
        end
      end
      mtk_pkg::PhGap: begin
        if (advance) begin
          state_d = mtk_pkg::PhOn;
          if (elem_q == mtk_pkg::LastElem) begin
            dig_d  = dig_q + 2'd1;
            elem_d = '0;
          end else begin
            elem_d = elem_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = mtk_pkg::PhIdle;
      end
    endcase
  end

  // segment fields and queue pop
  always_comb begin
    seg        = '0;
    cmd_take_o = 1'b0;
    word_add   = '0;
    case (state_q)
      mtk_pkg::PhIdle: begin
        cmd_take_o = !cmd_empty_i;
      end
      mtk_pkg::PhOn: begin
        seg.motor_on     = 1'b1;
        seg.duration_ms  = {1'b0, elem_dash ? cfg_i.dash_ms : cfg_i.dot_ms};
        seg.digit_slot   = dig_q;
        seg.last_segment = is_last;
        cmd_take_o       = advance && is_last && !cmd_empty_i;
      end
      mtk_pkg::PhGap: begin
        seg.digit_slot = dig_q;
        if (elem_q == mtk_pkg::LastElem) begin
          // hour/minute boundary carries the word gap in the same segment
          if (dig_q == mtk_pkg::SlotHourUnit) begin
            word_add = {1'b0, cfg_i.word_gap_ms};
          end
          seg.duration_ms = {1'b0, cfg_i.digit_gap_ms} + word_add;
        end else begin
          seg.duration_ms = {1'b0, cfg_i.element_gap_ms};
        end
      end
      default: begin
        seg = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtk_pkg::PhIdle;
      dig_q       <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_q       <= dig_d;
      elem_q      <= elem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (advance) begin
      out_seg_q <= seg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_seg_o   = out_seg_q;

endmodule

`default_nettype wire

// File: src/time_to_morse_vibe_segments_unit.sv
// ----------------------------------------------------------------------------
// time_to_morse_vibe_segments_unit: Morse time keyer
// Turns hour/minute requests into alternating vibrate/silent segments.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | push_i / full_o    | hour_i, minute_i, skip_hour_i
//  segment  | pop_i / empty_o    | duration_ms_o, motor_on_o, digit_slot_o,
//           |                    | last_segment_o
//  config   | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
//  One segment per cycle from the sequencer while pops keep up: 39 segments
//  for a full request, 19 for minutes only, after a load step when it was
//  idle; requests queue up (CmdDepth deep) behind it.
//  First segment shows on empty_o via the queue, load and output registers.
//  A held-off pop stalls the sequencer; the queue takes pushes until full.
//  Reset restores register defaults and empties both queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module time_to_morse_vibe_segments_unit #(
  parameter int unsigned CmdDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [4:0]                    hour_i,
  input  wire logic [5:0]                    minute_i,
  input  wire logic                          skip_hour_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic [mtk_pkg::DurW-1:0]           duration_ms_o,
  output logic                               motor_on_o,
  output logic [1:0]                         digit_slot_o,
  output logic                               last_segment_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mtk_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [mtk_pkg::CfgDataW-1:0]  cfg_data_i
);

  mtk_pkg::cfg_t cfg_q;
  mtk_pkg::cmd_t front_cmd;
  mtk_pkg::cmd_t fifo_cmd;
  mtk_pkg::seg_t seg;
  logic          fifo_empty;
  logic          cmd_take;
  logic          out_valid;
  logic          cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_24_hour    <= 1'b1;
      cfg_q.dot_ms         <= mtk_pkg::RstDotMs;
      cfg_q.dash_ms        <= mtk_pkg::RstDashMs;
      cfg_q.element_gap_ms <= mtk_pkg::RstElemGapMs;
      cfg_q.digit_gap_ms   <= mtk_pkg::RstDigitGapMs;
      cfg_q.word_gap_ms    <= mtk_pkg::RstWordGapMs;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        mtk_pkg::CfgUse24Hour:  cfg_q.use_24_hour    <= cfg_data_i[0];
        mtk_pkg::CfgDotMs:      cfg_q.dot_ms         <= cfg_data_i;
        mtk_pkg::CfgDashMs:     cfg_q.dash_ms        <= cfg_data_i;
        mtk_pkg::CfgElemGapMs:  cfg_q.element_gap_ms <= cfg_data_i;
        mtk_pkg::CfgDigitGapMs: cfg_q.digit_gap_ms   <= cfg_data_i;
        mtk_pkg::CfgWordGapMs:  cfg_q.word_gap_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mtk_front u_front (
    .use_24_hour_i (cfg_q.use_24_hour),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .skip_hour_i   (skip_hour_i),
    .cmd_o         (front_cmd)
  );

  mtk_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (front_cmd),
    .full_o    (full_o),
    .rd_en_i   (cmd_take),
    .rd_data_o (fifo_cmd),
    .empty_o   (fifo_empty)
  );

  mtk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (fifo_cmd),
    .cmd_empty_i (fifo_empty),
    .cmd_take_o  (cmd_take),
    .pop_i       (pop_i),
    .out_valid_o (out_valid),
    .out_seg_o   (seg)
  );

  assign empty_o        = !out_valid;
  assign duration_ms_o  = seg.duration_ms;
  assign motor_on_o     = seg.motor_on;
  assign digit_slot_o   = seg.digit_slot;
  assign last_segment_o = seg.last_segment;

endmodule

`default_nettype wire

// File: src/mtk_checker.sv
// ----------------------------------------------------------------------------
// mtk_checker: port-level checks for the Morse time keyer
// Watches the segment channel and flags malformed segments.
// ----------------------------------------------------------------------------
`default_nettype none

module mtk_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         empty_o,
  input wire logic                         pop_i,
  input wire logic [mtk_pkg::DurW-1:0]     duration_ms_o,
  input wire logic                         motor_on_o,
  input wire logic [1:0]                   digit_slot_o,
  input wire logic                         last_segment_o
);

  // a waiting segment holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(duration_ms_o) && $stable(motor_on_o))
    else $error("waiting segment changed before pop");

  // the final segment is an element of the minute units digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && last_segment_o |-> motor_on_o && digit_slot_o == mtk_pkg::SlotMinUnit)
    else $error("last segment is not a minute-units element");

  // a gap segment is never flagged last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !motor_on_o |-> !last_segment_o)
    else $error("gap segment flagged last");

  // element durations come from 10-bit registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && motor_on_o |-> duration_ms_o[mtk_pkg::DurW-1] == 1'b0)
    else $error("element duration out of range");

endmodule

bind time_to_morse_vibe_segments_unit mtk_checker u_mtk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty_o        (empty_o),
  .pop_i          (pop_i),
  .duration_ms_o  (duration_ms_o),
  .motor_on_o     (motor_on_o),
  .digit_slot_o   (digit_slot_o),
  .last_segment_o (last_segment_o)
);

`default_nettype wire

// File: tb/sv/time_to_morse_vibe_segments_unit_tb.sv
// ----------------------------------------------------------------------------
// time_to_morse_vibe_segments_unit_tb: self-checking bench for the Morse keyer
// Drives time requests and register writes, keys each request in a local
// model and compares every popped segment with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module time_to_morse_vibe_segments_unit_tb;

  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned MaxPrints   = 40;
  localparam int unsigned RoundItems  = 38;
  localparam int unsigned PressItems  = 10;
  localparam int unsigned NumRows     = 29;

  // indexes past the last register: writes must be ignored
  localparam logic [mtk_pkg::CfgIdxW-1:0] CfgNoReg6 = 3'd6;
  localparam logic [mtk_pkg::CfgIdxW-1:0] CfgNoReg7 = 3'd7;

  localparam int unsigned SendIdlePct [4] = '{0, 53, 0, 19};
  localparam int unsigned PopStallPct [4] = '{0, 0, 53, 19};

  typedef enum logic {
    RowReq,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [mtk_pkg::CfgIdxW-1:0]  idx;
    logic [mtk_pkg::CfgDataW-1:0] data;
    logic [4:0]                   hour;
    logic [5:0]                   minute;
    logic                         skip_hour;
    logic                         has_exp;
    mtk_pkg::seg_t                first_seg;
  } row_t;

  // first segment typed in only where it is obvious
  localparam row_t DirRows [NumRows] = '{
    '{RowReq, '0, '0, 5'd0,  6'd0,  1'b0, 1'b1, '{11'd300, 1'b1, mtk_pkg::SlotHourTens, 1'b0}},
    '{RowReq, '0, '0, 5'd23, 6'd59, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd31, 6'd63, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd12, 6'd34, 1'b1, 1'b1, '{11'd100, 1'b1, mtk_pkg::SlotMinTens, 1'b0}},
    '{RowReq, '0, '0, 5'd19, 6'd5,  1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgUse24Hour,  10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd0,  6'd0,  1'b0, 1'b1, '{11'd100, 1'b1, mtk_pkg::SlotHourTens, 1'b0}},
    '{RowReq, '0, '0, 5'd12, 6'd0,  1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd13, 6'd45, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd24, 6'd10, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd31, 6'd59, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDotMs,      10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDashMs,     10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgElemGapMs,  10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDigitGapMs, 10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgWordGapMs,  10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd11, 6'd59, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd0,  6'd7,  1'b1, 1'b1, '{11'd1023, 1'b1, mtk_pkg::SlotMinTens, 1'b0}},
    '{RowCfg, mtk_pkg::CfgWordGapMs,  10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDigitGapMs, 10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDotMs,      10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgDashMs,     10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgElemGapMs,  10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, mtk_pkg::CfgUse24Hour,  10'd1,    '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgNoReg6,              10'd1023, '0, '0, 1'b0, 1'b0, '0},
    '{RowCfg, CfgNoReg7,              10'd0,    '0, '0, 1'b0, 1'b0, '0},
    '{RowReq, '0, '0, 5'd9,  6'd8,  1'b0, 1'b1, '{11'd0, 1'b1, mtk_pkg::SlotHourTens, 1'b0}},
    '{RowReq, '0, '0, 5'd20, 6'd17, 1'b1, 1'b0, '0},
    '{RowReq, '0, '0, 5'd16, 6'd0,  1'b0, 1'b0, '0}
  };

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         push_i      = 1'b0;
  logic [4:0]                   hour_i      = '0;
  logic [5:0]                   minute_i    = '0;
  logic                         skip_hour_i = 1'b0;
  logic                         pop_i       = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic [mtk_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mtk_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         full_o;
  logic                         empty_o;
  logic [mtk_pkg::DurW-1:0]     duration_ms_o;
  logic                         motor_on_o;
  logic [1:0]                   digit_slot_o;
  logic                         last_segment_o;
  logic                         cfg_ready_o;

  // outputs as seen mid-cycle, read at the next rising edge
  logic          full_s;
  logic          empty_s;
  logic          cfg_ready_s;
  mtk_pkg::seg_t out_s;

  mtk_pkg::cfg_t key_cfg;
  mtk_pkg::seg_t segs_due[$];
  int unsigned   err_cnt       = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   pop_stall_pct = 0;
  logic          hold_pop      = 1'b0;

  time_to_morse_vibe_segments_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .skip_hour_i    (skip_hour_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .duration_ms_o  (duration_ms_o),
    .motor_on_o     (motor_on_o),
    .digit_slot_o   (digit_slot_o),
    .last_segment_o (last_segment_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    full_s      = full_o;
    empty_s     = empty_o;
    cfg_ready_s = cfg_ready_o;
    out_s       = '{duration_ms_o, motor_on_o, digit_slot_o, last_segment_o};
  end

  function automatic mtk_pkg::seg_t make_seg(input logic [mtk_pkg::DurW-1:0] dur,
                                             input logic on, input logic [1:0] slot,
                                             input logic last);
    mtk_pkg::seg_t s;
    s.duration_ms  = dur;
    s.motor_on     = on;
    s.digit_slot   = slot;
    s.last_segment = last;
    return s;
  endfunction

  // segments that one request turns into under the given registers
  function automatic void key_time(input logic [4:0] hour, input logic [5:0] minute,
                                   input logic mins_only, input mtk_pkg::cfg_t cfg,
                                   ref mtk_pkg::seg_t segs[$]);
    int unsigned              h;
    int unsigned              dig [4];
    int unsigned              first;
    logic                     dash;
    logic [mtk_pkg::DurW-1:0] gap;
    h = hour;
    if (!cfg.use_24_hour) begin
      h = h % 12;
      if (h == 0) h = 12;
    end
    dig[0] = h / 10;
    dig[1] = h % 10;
    dig[2] = minute / 10;
    dig[3] = minute % 10;
    first = mins_only ? 2 : 0;
    segs.delete();
    for (int d = first; d < 4; d++) begin
      if (d > first) begin
        gap = {1'b0, cfg.digit_gap_ms};
        if (d == 2 && !mins_only) gap = gap + {1'b0, cfg.word_gap_ms};
        segs.push_back(make_seg(gap, 1'b0, 2'(d - 1), 1'b0));
      end
      for (int e = 0; e < 5; e++) begin
        // 0..5: dashes from element n on; 6..9: dashes below element n-5
        dash = (dig[d] <= 5) ? (e >= dig[d]) : (e < dig[d] - 5);
        if (e > 0) segs.push_back(make_seg({1'b0, cfg.element_gap_ms}, 1'b0, 2'(d), 1'b0));
        segs.push_back(make_seg(dash ? {1'b0, cfg.dash_ms} : {1'b0, cfg.dot_ms}, 1'b1,
                                2'(d), (d == 3 && e == 4)));
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MaxPrints) $display("mismatch: %s", msg);
  endtask

  task automatic check_segment(input mtk_pkg::seg_t got);
    mtk_pkg::seg_t want;
    if (segs_due.size() == 0) begin
      report_mismatch($sformatf("segment dur=%0d on=%0b slot=%0d last=%0b with none due",
                                got.duration_ms, got.motor_on, got.digit_slot,
                                got.last_segment));
      return;
    end
    want = segs_due.pop_front();
    if (got.duration_ms !== want.duration_ms)
      report_mismatch($sformatf("duration_ms %0d, want %0d", got.duration_ms,
                                want.duration_ms));
    if (got.motor_on !== want.motor_on)
      report_mismatch($sformatf("motor_on %0b, want %0b", got.motor_on, want.motor_on));
    if (got.digit_slot !== want.digit_slot)
      report_mismatch($sformatf("digit_slot %0d, want %0d", got.digit_slot,
                                want.digit_slot));
    if (got.last_segment !== want.last_segment)
      report_mismatch($sformatf("last_segment %0b, want %0b", got.last_segment,
                                want.last_segment));
  endtask

  // leaves valid high so back-to-back writes follow without a gap
  task automatic write_reg(input logic [mtk_pkg::CfgIdxW-1:0] idx,
                           input logic [mtk_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_s) @(posedge clk_i);
    case (idx)
      mtk_pkg::CfgUse24Hour:  key_cfg.use_24_hour    = data[0];
      mtk_pkg::CfgDotMs:      key_cfg.dot_ms         = data;
      mtk_pkg::CfgDashMs:     key_cfg.dash_ms        = data;
      mtk_pkg::CfgElemGapMs:  key_cfg.element_gap_ms = data;
      mtk_pkg::CfgDigitGapMs: key_cfg.digit_gap_ms   = data;
      mtk_pkg::CfgWordGapMs:  key_cfg.word_gap_ms    = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    push_i      <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (segs_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_request(input logic [4:0] hour, input logic [5:0] minute,
                              input logic mins_only, input logic has_exp,
                              input mtk_pkg::seg_t first_seg);
    mtk_pkg::seg_t segs[$];
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i      <= 1'b1;
    hour_i      <= hour;
    minute_i    <= minute;
    skip_hour_i <= mins_only;
    @(posedge clk_i);
    while (full_s) @(posedge clk_i);
    key_time(hour, minute, mins_only, key_cfg, segs);
    if (has_exp) segs[0] = first_seg;
    foreach (segs[i]) segs_due.push_back(segs[i]);
  endtask

  task automatic send_random();
    logic [4:0] hour;
    logic [5:0] minute;
    hour   = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    minute = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    send_request(hour, minute, $urandom_range(3) == 0, 1'b0, '0);
  endtask

  function automatic logic [mtk_pkg::CfgDataW-1:0] pick_ms();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 10'd1;
      2:       return '1;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic shuffle_regs();
    write_reg(mtk_pkg::CfgUse24Hour, 10'($urandom_range(1)));
    write_reg(mtk_pkg::CfgDotMs, pick_ms());
    write_reg(mtk_pkg::CfgDashMs, pick_ms());
    write_reg(mtk_pkg::CfgElemGapMs, pick_ms());
    write_reg(mtk_pkg::CfgDigitGapMs, pick_ms());
    write_reg(mtk_pkg::CfgWordGapMs, pick_ms());
  endtask

  // receiver: pops with random stalls, or holds off while hold_pop is set
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_s) check_segment(out_s);
      pop_i <= !hold_pop && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  initial begin
    key_cfg = '{1'b1, mtk_pkg::RstDotMs, mtk_pkg::RstDashMs, mtk_pkg::RstElemGapMs,
                mtk_pkg::RstDigitGapMs, mtk_pkg::RstWordGapMs};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      if (DirRows[r].kind == RowCfg) begin
        wait_idle();
        write_reg(DirRows[r].idx, DirRows[r].data);
      end else begin
        send_request(DirRows[r].hour, DirRows[r].minute, DirRows[r].skip_hour,
                     DirRows[r].has_exp, DirRows[r].first_seg);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SendIdlePct[p];
      pop_stall_pct = PopStallPct[p];
      repeat (2) begin
        wait_idle();
        shuffle_regs();
        repeat (RoundItems) send_random();
      end
    end

    // long pop hold-off: request queue fills and push stalls on full
    wait_idle();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fork
      begin
        hold_pop <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_pop <= 1'b0;
      end
      repeat (PressItems) send_random();
    join

    push_i      <= 1'b0;
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < DrainLimit && segs_due.size() != 0; i++) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (segs_due.size() != 0)
      report_mismatch($sformatf("%0d segments never came", segs_due.size()));
    if (err_cnt == 0) begin
      $display("time_to_morse_vibe_segments_unit_tb: PASS");
    end else begin
      $display("time_to_morse_vibe_segments_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("time_to_morse_vibe_segments_unit_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/mtk_pkg.sv
src/mtk_front.sv
src/mtk_cmd_fifo.sv
src/mtk_back.sv
src/time_to_morse_vibe_segments_unit.sv
src/mtk_checker.sv
tb/sv/time_to_morse_vibe_segments_unit_tb.sv
